[hw/rtl/dbe_pkg.sv]
// Shared constants, types and helper functions for the Bareiss determinant block.
package dbe_pkg;

   // Matrix store geometry.
   localparam int MAX_DIM = 8;
   localparam int DIM_W = $clog2(MAX_DIM);
   localparam int ADDR_W = 2 * DIM_W;
   localparam int CNT_W = DIM_W + 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM;

   // Fixed field widths.
   localparam int DATA_W = 64;
   localparam int INDEX_W = 3;
   localparam int SIZE_W = 4;
   localparam int SZ_CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

   // Request queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      KIND_WRITE,
      KIND_START
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [CNT_W-1:0]      row;
      logic [CNT_W-1:0]      col;
      logic [DATA_W-1:0]     value;
      logic [CNT_W-1:0]      size;
   } item_type;

   // Absolute value of a two's complement word, as an unsigned word.
   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
      magnitude = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
   endfunction

   // Store address of an entry.
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [CNT_W-1:0] r,
                                                     input logic [CNT_W-1:0] c);
      entry_addr = {r[DIM_W-1:0], c[DIM_W-1:0]};
   endfunction

endpackage

[hw/rtl/dbe_front.sv]
// Front end: holds the size register and classifies requests into queue items.
module dbe_front import dbe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [INDEX_W-1:0]  req_row,
   input  logic [INDEX_W-1:0]  req_col,
   input  logic [DATA_W-1:0]   req_value,
   input  logic                csr_we,
   input  logic [SIZE_W-1:0]   csr_wdata,
   input  logic                queue_full,
   output logic                push,
   output item_type            push_item
);

   logic [SIZE_W-1:0] size_ff;
   logic              accept;
   logic              in_range;

   // Size register, reset to the full store.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(MAX_DIM);
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;

   // A write outside the store is dropped here; starts carry the clamped size.
   always_comb begin
      push_item.kind = req_cmd ? KIND_START : KIND_WRITE;
      push_item.row = CNT_W'(req_row);
      push_item.col = CNT_W'(req_col);
      push_item.value = req_value;
      if (SZ_CMP_W'(size_ff) > SZ_CMP_W'(MAX_DIM)) begin
         push_item.size = CNT_W'(MAX_DIM);
      end else begin
         push_item.size = CNT_W'(size_ff);
      end
      in_range = (push_item.row < CNT_W'(MAX_DIM)) && (push_item.col < CNT_W'(MAX_DIM));
      push = accept && (req_cmd || in_range);
   end

endmodule

[hw/rtl/dbe_queue.sv]
// Short request queue between the front end and the elimination engine.
module dbe_queue import dbe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff;
   logic [QPTR_W-1:0] rptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = slot_ff[rptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   // Payload slots.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

[hw/rtl/dbe_engine.sv]
// Back end: matrix store, Bareiss elimination sequencer, serial multiplier and divider.
module dbe_engine import dbe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  item_type           head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_determinant,
   output logic               rsp_singular
);

   typedef enum logic [4:0] {
      S_IDLE, S_PIV_RD, S_PIV_CHK, S_SRCH_RD, S_SRCH_CHK,
      S_SW_RDA, S_SW_RDB, S_SW_WRA, S_SW_WRB,
      S_ROW_RD, S_ROW_GET, S_EL_RDA, S_EL_RDB, S_EL_GET,
      S_MUL, S_ACC, S_NEG, S_DIV, S_WB, S_NEXT_K, S_FIN_RD, S_FIN, S_SING, S_DONE
   } state_type;

   localparam int ACC_W = 2 * DATA_W;

   state_type          state_ff;
   logic [DATA_W-1:0]  mem [DEPTH];
   logic [DATA_W-1:0]  rd_ff;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic               mem_we;

   logic [CNT_W-1:0]   n_ff, k_ff, i_ff, j_ff, p_ff;
   logic [DATA_W-1:0]  piv_ff, prev_ff, dm_ff, tmp_ff;
   logic [DATA_W-1:0]  aij_ff, aik_ff, akj_ff;
   logic               sign_ff;
   logic [2:0]         part_ff;
   logic [DATA_W-1:0]  pp_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   num_ff;
   logic               nneg_ff;
   logic [DATA_W-1:0]  rem_ff, quo_ff;
   logic [6:0]         cnt_ff;
   logic [DATA_W-1:0]  res_det_ff;
   logic               res_sing_ff;
   logic               out_valid_ff;
   logic [DATA_W-1:0]  out_det_ff;
   logic               out_sing_ff;

   logic [DATA_W-1:0]  op_a, op_b;
   logic [31:0]        half_a, half_b;
   logic               neg_term;
   logic [ACC_W-1:0]   pp_shifted;
   logic [DATA_W:0]    rem_in;
   logic [DATA_W:0]    rem_sub;
   logic [DATA_W-1:0]  upd_in;
   logic [CNT_W-1:0]   j_in, i_in;

   // Partial product operand selection: first a[i][j]*pivot, then a[i][k]*a[k][j].
   always_comb begin
      op_a = part_ff[2] ? magnitude(aik_ff) : magnitude(aij_ff);
      op_b = part_ff[2] ? magnitude(akj_ff) : magnitude(piv_ff);
      half_a = part_ff[1] ? op_a[63:32] : op_a[31:0];
      half_b = part_ff[0] ? op_b[63:32] : op_b[31:0];
      neg_term = part_ff[2] ? !(aik_ff[63] ^ akj_ff[63]) : (aij_ff[63] ^ piv_ff[63]);
      pp_shifted = {{DATA_W{1'b0}}, pp_ff}
                   << {({1'b0, part_ff[1]} + {1'b0, part_ff[0]}), 5'b0};
   end

   // One restoring division step and the signed quotient.
   always_comb begin
      rem_in = {rem_ff, num_ff[ACC_W-1]};
      rem_sub = rem_in - {1'b0, dm_ff};
      upd_in = (nneg_ff ^ prev_ff[63]) ? (~quo_ff + DATA_W'(1)) : quo_ff;
      j_in = j_ff + CNT_W'(1);
      i_in = i_ff + CNT_W'(1);
   end

   // Store port addressing per state.
   always_comb begin
      mem_raddr = entry_addr(k_ff, k_ff);
      mem_waddr = entry_addr(head.row, head.col);
      mem_wdata = head.value;
      mem_we = 1'b0;
      pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pop = not_empty;
            mem_we = not_empty && (head.kind == KIND_WRITE);
         end
         S_SRCH_RD:  mem_raddr = entry_addr(i_ff, k_ff);
         S_SW_RDA:   mem_raddr = entry_addr(k_ff, j_ff);
         S_SW_RDB:   mem_raddr = entry_addr(p_ff, j_ff);
         S_SW_WRA: begin
            mem_we = 1'b1;
            mem_waddr = entry_addr(k_ff, j_ff);
            mem_wdata = rd_ff;
         end
         S_SW_WRB: begin
            mem_we = 1'b1;
            mem_waddr = entry_addr(p_ff, j_ff);
            mem_wdata = tmp_ff;
         end
         S_ROW_RD:   mem_raddr = entry_addr(i_ff, k_ff);
         S_EL_RDA:   mem_raddr = entry_addr(k_ff, j_ff);
         S_EL_RDB:   mem_raddr = entry_addr(i_ff, j_ff);
         S_WB: begin
            mem_we = 1'b1;
            mem_waddr = entry_addr(i_ff, j_ff);
            mem_wdata = upd_in;
         end
         S_FIN_RD:   mem_raddr = entry_addr(n_ff - CNT_W'(1), n_ff - CNT_W'(1));
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Matrix store with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   // Elimination sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         prev_ff <= DATA_W'(1);
         dm_ff <= DATA_W'(1);
         sign_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (not_empty && head.kind == KIND_START) begin
                  n_ff <= head.size;
                  k_ff <= '0;
                  prev_ff <= DATA_W'(1);
                  dm_ff <= DATA_W'(1);
                  sign_ff <= 1'b0;
                  if (head.size == '0) begin
                     res_det_ff <= DATA_W'(1);
                     res_sing_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_PIV_RD;
                  end
               end
            end
            S_PIV_RD: state_ff <= S_PIV_CHK;
            // Nonzero pivot: row updates, zero: search; at last k, next k or singular.
            S_PIV_CHK: begin
               i_ff <= k_ff + CNT_W'(1);
               if (rd_ff != '0) begin
                  piv_ff <= rd_ff;
                  state_ff <= (k_ff + CNT_W'(1) >= n_ff) ? S_NEXT_K : S_ROW_RD;
               end else begin
                  state_ff <= (k_ff + CNT_W'(1) >= n_ff) ? S_SING : S_SRCH_RD;
               end
            end
            S_SRCH_RD: state_ff <= S_SRCH_CHK;
            S_SRCH_CHK: begin
               if (rd_ff != '0) begin
                  p_ff <= i_ff;
                  j_ff <= '0;
                  sign_ff <= !sign_ff;
                  state_ff <= S_SW_RDA;
               end else begin
                  i_ff <= i_in;
                  state_ff <= (i_in >= n_ff) ? S_SING : S_SRCH_RD;
               end
            end
            // Row exchange over the active columns.
            S_SW_RDA: state_ff <= S_SW_RDB;
            S_SW_RDB: begin
               tmp_ff <= rd_ff;
               state_ff <= S_SW_WRA;
            end
            S_SW_WRA: state_ff <= S_SW_WRB;
            S_SW_WRB: begin
               j_ff <= j_in;
               state_ff <= (j_in >= n_ff) ? S_PIV_RD : S_SW_RDA;
            end
            S_ROW_RD: state_ff <= S_ROW_GET;
            S_ROW_GET: begin
               aik_ff <= rd_ff;
               j_ff <= k_ff + CNT_W'(1);
               state_ff <= S_EL_RDA;
            end
            S_EL_RDA: state_ff <= S_EL_RDB;
            S_EL_RDB: begin
               akj_ff <= rd_ff;
               state_ff <= S_EL_GET;
            end
            S_EL_GET: begin
               aij_ff <= rd_ff;
               acc_ff <= '0;
               part_ff <= '0;
               state_ff <= S_MUL;
            end
            // Eight 32x32 partial products, each accumulated in the next cycle.
            S_MUL: begin
               pp_ff <= DATA_W'(half_a) * DATA_W'(half_b);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= neg_term ? (acc_ff - pp_shifted) : (acc_ff + pp_shifted);
               part_ff <= part_ff + 3'd1;
               state_ff <= (part_ff == 3'd7) ? S_NEG : S_MUL;
            end
            S_NEG: begin
               nneg_ff <= acc_ff[ACC_W-1];
               num_ff <= acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= 7'd127;
               state_ff <= S_DIV;
            end
            // One quotient bit per cycle; only the low 64 quotient bits are kept.
            S_DIV: begin
               num_ff <= {num_ff[ACC_W-2:0], 1'b0};
               if (!rem_sub[DATA_W]) begin
                  rem_ff <= rem_sub[DATA_W-1:0];
                  quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_in[DATA_W-1:0];
                  quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 7'd1;
               if (cnt_ff == '0) begin
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               if (j_in >= n_ff) begin
                  i_ff <= i_in;
                  state_ff <= (i_in >= n_ff) ? S_NEXT_K : S_ROW_RD;
               end else begin
                  j_ff <= j_in;
                  state_ff <= S_EL_RDA;
               end
            end
            S_NEXT_K: begin
               prev_ff <= piv_ff;
               dm_ff <= magnitude(piv_ff);
               k_ff <= k_ff + CNT_W'(1);
               state_ff <= (k_ff + CNT_W'(1) >= n_ff) ? S_FIN_RD : S_PIV_RD;
            end
            S_FIN_RD: state_ff <= S_FIN;
            S_FIN: begin
               res_det_ff <= sign_ff ? (~rd_ff + DATA_W'(1)) : rd_ff;
               res_sing_ff <= 1'b0;
               state_ff <= S_DONE;
            end
            S_SING: begin
               res_det_ff <= '0;
               res_sing_ff <= 1'b1;
               state_ff <= S_DONE;
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
               if (!out_valid_ff || !rsp_stall) begin
                  out_valid_ff <= 1'b1;
                  out_det_ff <= res_det_ff;
                  out_sing_ff <= res_sing_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_determinant = out_det_ff;
   assign rsp_singular = out_sing_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dm_ff != '0))
      else $error("division by a zero pivot");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sing_ff) |-> (out_det_ff == '0))
      else $error("singular result with nonzero determinant");

   a_update_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> ((i_ff < n_ff) && (j_ff < n_ff) && (k_ff < i_ff)))
      else $error("update outside the active region");

endmodule

[hw/rtl/determinant_bareiss_exact_top.sv]
// Top level of the exact Bareiss determinant block.
//
// Requests arrive on req_valid/req_stall with req_cmd, req_row, req_col and
// req_value. A write request (req_cmd 0) stores one signed 64-bit entry; a
// start request (req_cmd 1) computes the determinant of the active n by n
// region, n set by csr_wdata on csr_we (reset value 8, above 8 acts as 8).
// Each start gives one response on rsp_valid/rsp_stall with rsp_determinant
// and rsp_singular; writes give none. The store is overwritten by a start.
// A four-entry request queue decouples the front end from the engine, so
// writes are taken one per cycle while the queue is not full and land in the store when the engine pops them.
// Each element update runs eight 32x32 multiply-accumulate steps and then the
// bit-serial 128-step divider; a start also spends time on row swaps.
// A stalled response is held in the output register while the engine keeps
// draining writes; the next result waits in the engine until it is taken.
// Reset (synchronous) empties the queue, drops any pending response and sets
// the size back to 8; the matrix store must be reloaded after reset.
module determinant_bareiss_exact_top import dbe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [INDEX_W-1:0]  req_row,
   input  logic [INDEX_W-1:0]  req_col,
   input  logic [DATA_W-1:0]   req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_determinant,
   output logic                rsp_singular,
   input  logic                csr_we,
   input  logic [SIZE_W-1:0]   csr_wdata
);

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     not_empty;
   item_type head;

   dbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   dbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   dbe_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .not_empty       (not_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_determinant (rsp_determinant),
      .rsp_singular    (rsp_singular)
   );

endmodule

[tb/determinant_bareiss_exact_top_tb.sv]
// Self-checking testbench for the exact Bareiss determinant block.
`timescale 1ns / 100ps

module determinant_bareiss_exact_top_tb;
   import dbe_pkg::*;

   typedef struct {
      kind_type            kind;
      logic [INDEX_W-1:0]  row;
      logic [INDEX_W-1:0]  col;
      logic [DATA_W-1:0]   value;
   } request_type;

   typedef struct {
      logic [DATA_W-1:0]   det;
      logic                singular;
   } det_result_type;

   localparam int TARGET_REQUESTS = 1900;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int LONG_HOLD = 1500;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = 1'b0;
   logic [INDEX_W-1:0]  req_row = '0;
   logic [INDEX_W-1:0]  req_col = '0;
   logic [DATA_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_determinant;
   logic                rsp_singular;
   logic                csr_we = 1'b0;
   logic [SIZE_W-1:0]   csr_wdata = '0;

   request_type      pending_reqs[$];
   det_result_type   expected_dets[$];
   request_type      cur_req;
   int            error_count = 0;
   int            requests_queued = 0;
   int            requests_accepted = 0;
   int            results_checked = 0;
   int            cycle_count = 0;
   int            send_gap = 0;
   int            recv_wait = 0;
   int            recv_draw = 0;
   int            hold_left = 0;
   bit            no_gaps = 0;

   // Predictor state: its own copy of the matrix and the size register.
   logic [DATA_W-1:0] model_mat[MAX_DIM][MAX_DIM];
   logic [SIZE_W-1:0] model_size = SIZE_W'(8);

   determinant_bareiss_exact_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_determinant(rsp_determinant), .rsp_singular(rsp_singular),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // One fraction-free update: (a*d - b*c) / div, truncated toward zero, low 64 bits.
   function automatic logic [DATA_W-1:0] frac_free(input logic [DATA_W-1:0] a,
         input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] b,
         input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] div);
      logic [127:0] pa, pb, num, mag, quo;
      logic [DATA_W-1:0] dm;
      logic nneg;
      pa = {{64{a[63]}}, a} * {{64{d[63]}}, d};
      pb = {{64{b[63]}}, b} * {{64{c[63]}}, c};
      num = pa - pb;
      nneg = num[127];
      mag = nneg ? -num : num;
      dm = div[63] ? -div : div;
      if (dm == '0) return '0;
      quo = mag / {64'b0, dm};
      return (nneg != div[63]) ? -quo[63:0] : quo[63:0];
   endfunction

   // Runs the elimination in place on the predictor's matrix.
   function automatic det_result_type eliminate();
      det_result_type res;
      int n, p;
      logic [DATA_W-1:0] prev, tmp;
      bit neg;
      n = (model_size > MAX_DIM) ? MAX_DIM : int'(model_size);
      prev = 64'd1;
      neg = 0;
      for (int k = 0; k < n; k++) begin
         if (model_mat[k][k] == '0) begin
            p = n;
            for (int i = k + 1; i < n; i++) begin
               if (p == n && model_mat[i][k] != '0) p = i;
            end
            if (p == n) begin
               res.det = '0;
               res.singular = 1'b1;
               return res;
            end
            for (int j = 0; j < n; j++) begin
               tmp = model_mat[k][j];
               model_mat[k][j] = model_mat[p][j];
               model_mat[p][j] = tmp;
            end
            neg = ~neg;
         end
         for (int i = k + 1; i < n; i++) begin
            for (int j = k + 1; j < n; j++) begin
               model_mat[i][j] = frac_free(model_mat[i][j], model_mat[k][k],
                                           model_mat[i][k], model_mat[k][j], prev);
            end
         end
         prev = model_mat[k][k];
      end
      res.singular = 1'b0;
      if (n == 0) res.det = 64'd1;
      else res.det = neg ? -model_mat[n-1][n-1] : model_mat[n-1][n-1];
      return res;
   endfunction

   // Request driver: takes items from the pending queue with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (cur_req.kind == KIND_WRITE) begin
               model_mat[cur_req.row][cur_req.col] = cur_req.value;
            end else begin
               expected_dets.push_back(eliminate());
            end
            requests_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= (cur_req.kind == KIND_START);
               req_row <= cur_req.row;
               req_col <= cur_req.col;
               req_value <= cur_req.value;
               send_gap <= no_gaps ? 0 : $urandom_range(0, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random stalls, two long holds, field-by-field checks.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dets.size() == 0) begin
               $display("%0t: unexpected response det=%h singular=%b",
                        $time, rsp_determinant, rsp_singular);
               error_count++;
            end else begin
               det_result_type exp_res;
               exp_res = expected_dets.pop_front();
               if (rsp_determinant !== exp_res.det) begin
                  $display("%0t: determinant expected %h actual %h",
                           $time, exp_res.det, rsp_determinant);
                  error_count++;
               end
               if (rsp_singular !== exp_res.singular) begin
                  $display("%0t: singular expected %b actual %b",
                           $time, exp_res.singular, rsp_singular);
                  error_count++;
               end
            end
            results_checked++;
            if (results_checked == 10 || results_checked == 50) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            recv_draw = no_gaps ? 0 : $urandom_range(0, 19);
            recv_wait <= recv_draw;
            rsp_stall <= (recv_draw > 0);
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= (recv_wait > 1);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("determinant_bareiss_exact_top_tb: errors");
         $finish;
      end
   end

   task automatic push_write(input int r, input int c, input logic [DATA_W-1:0] v);
      request_type rq;
      rq.kind = KIND_WRITE;
      rq.row = INDEX_W'(r);
      rq.col = INDEX_W'(c);
      rq.value = v;
      pending_reqs.push_back(rq);
      requests_queued++;
   endtask

   task automatic push_start();
      request_type rq;
      rq.kind = KIND_START;
      rq.row = INDEX_W'($urandom_range(0, 7));
      rq.col = INDEX_W'($urandom_range(0, 7));
      rq.value = {$urandom, $urandom};
      pending_reqs.push_back(rq);
      requests_queued++;
   endtask

   // Waits until every request is taken, every result is in and writes drained.
   task automatic wait_idle();
      while (requests_accepted < requests_queued || expected_dets.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_size(input int sz);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= SIZE_W'(sz);
      model_size = SIZE_W'(sz);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Draws one matrix entry; the mix favors zeros and small values.
   function automatic logic [DATA_W-1:0] draw_entry(input int zero_pct);
      int sel;
      if ($urandom_range(0, 99) < zero_pct) return '0;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2, 3: return DATA_W'($signed($urandom_range(0, 10)) - 5);
         4, 5: return {{48{1'b0}}, 16'($urandom)} - 64'h8000;
         6, 7: return {$urandom, $urandom};
         8: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
         default: return $urandom_range(0, 1) ? 64'hffff_ffff_ffff_ffff : 64'd1;
      endcase
   endfunction

   // Queues one loaded matrix of dimension n in shuffled order, then a start, occasionally two.
   task automatic push_matrix(input int n);
      logic [DATA_W-1:0] m[MAX_DIM][MAX_DIM];
      int order[$];
      int shape, zpct, src, dst, t, idx;
      shape = $urandom_range(0, 9);
      zpct = (shape < 3) ? 50 : 15;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            m[r][c] = draw_entry(zpct);
      // Some matrices are singular by a repeated row or an empty column.
      if (shape == 3 && n >= 2) begin
         src = $urandom_range(0, n - 1);
         dst = $urandom_range(0, n - 1);
         for (int c = 0; c < n; c++) m[dst][c] = m[src][c];
      end else if (shape == 4 && n >= 1) begin
         src = $urandom_range(0, n - 1);
         for (int r = 0; r < n; r++) m[r][src] = '0;
      end
      // Stray writes anywhere in the store; the active region is written after.
      repeat ($urandom_range(0, 2))
         push_write($urandom_range(0, 7), $urandom_range(0, 7), {$urandom, $urandom});
      for (int i = 0; i < n * n; i++) order.push_back(i);
      for (int i = n * n - 1; i > 0; i--) begin
         idx = $urandom_range(0, i);
         t = order[i];
         order[i] = order[idx];
         order[idx] = t;
      end
      foreach (order[i]) push_write(order[i] / n, order[i] % n, m[order[i] / n][order[i] % n]);
      push_start();
      if ($urandom_range(0, 9) == 0) push_start();
   endtask

   initial begin
      int sz, sets, pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty matrix, 1x1 extremes and zero, 2x2 swap, singular and extremes.
      set_size(0);
      push_start();
      set_size(1);
      push_write(0, 0, 64'h8000_0000_0000_0000);
      push_start();
      push_write(0, 0, 64'h7fff_ffff_ffff_ffff);
      push_start();
      push_write(0, 0, '0);
      push_start();
      set_size(2);
      push_write(0, 0, '0);
      push_write(0, 1, 64'd7);
      push_write(1, 0, -64'sd3);
      push_write(1, 1, 64'd9);
      push_start();
      push_write(0, 0, '0);
      push_write(0, 1, 64'd5);
      push_write(1, 0, '0);
      push_write(1, 1, 64'd2);
      push_start();
      push_write(0, 0, 64'h8000_0000_0000_0000);
      push_write(0, 1, 64'h7fff_ffff_ffff_ffff);
      push_write(1, 0, 64'h8000_0000_0000_0000);
      push_write(1, 1, 64'h8000_0000_0000_0000);
      push_start();
      push_start();

      // Random phases, mostly small sizes, occasionally the full store.
      while (requests_queued < TARGET_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) sz = $urandom_range(8, 15);
         else if (pick < 15) sz = $urandom_range(5, 7);
         else sz = $urandom_range(0, 4);
         set_size(sz);
         no_gaps = ($urandom_range(0, 3) == 0);
         sets = (sz >= 8) ? 1 : (sz >= 5 ? $urandom_range(1, 2) : $urandom_range(2, 8));
         repeat (sets) push_matrix(sz > MAX_DIM ? MAX_DIM : sz);
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("determinant_bareiss_exact_top_tb: clean");
      else
         $display("determinant_bareiss_exact_top_tb: errors");
      $finish;
   end

endmodule

[determinant_bareiss_exact_top.f]
hw/rtl/dbe_pkg.sv
hw/rtl/dbe_front.sv
hw/rtl/dbe_queue.sv
hw/rtl/dbe_engine.sv
hw/rtl/determinant_bareiss_exact_top.sv
tb/determinant_bareiss_exact_top_tb.sv
